[design/sgrq_pkg.sv]
// ----------------------------------------------------------------------------
// sgrq_pkg
// shared types and constants of the sequence gap request queue
// ----------------------------------------------------------------------------
package sgrq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int SEQ_W       = 64;
  localparam int OUT_CNT_W   = 6;

  typedef struct packed {
    logic             mode;
    logic [SEQ_W-1:0] seq_value;
  } in_item_t;

  typedef struct packed {
    logic                 gap_found;
    logic [OUT_CNT_W-1:0] pushed_count;
    logic                 dropped;
    logic                 popped_valid;
    logic [SEQ_W-1:0]     popped_seq;
    logic [OUT_CNT_W-1:0] queue_level;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic push;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;
    logic cnt_last;
  } dp_status_t;

endpackage

[design/sequence_gap_request_queue_core.sv]
// ----------------------------------------------------------------------------
// sequence_gap_request_queue_core
// sequence gap detector that queues missing numbers in a ring memory
// ----------------------------------------------------------------------------
// usage
//   in_*  : valid/ready beat of {mode, seq_value}. mode 0 checks a number
//           against the last one seen and queues the skipped numbers that
//           fit the ring, flagging a drop; mode 1 pops the oldest queued one.
//   out_* : valid/ready beat with one result per input beat.
//   sequence: accept, an evaluate state, a push state per queued number,
//   then the result register loads in the output state.
//   overlap: the next beat is taken in the cycle the result loads; each
//   number written takes its own push state, as the ring memory has a
//   single write port.
//   reset: last seen number and both ring pointers clear; ring contents are
//   not cleared and need no clearing pass since a pop only reads written
//   entries.
//   stall: a held result sits in the output register; the next beat is still
//   taken and worked, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module sequence_gap_request_queue_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgrq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sgrq_pkg::out_item_t out_data
);

  // command and status between controller and datapath
  sgrq_pkg::ctrl_cmd_t  cmd;
  sgrq_pkg::dp_status_t status;

  // controller owns the handshakes and the result valid flag
  sgrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath holds the sequence state, the ring and the result payload
  sgrq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

[design/sgrq_dp.sv]
// ----------------------------------------------------------------------------
// sgrq_dp
// datapath: input capture, gap arithmetic, ring memory and result register
// ----------------------------------------------------------------------------
module sgrq_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sgrq_pkg::in_item_t  in_data,
  input  sgrq_pkg::ctrl_cmd_t cmd,
  output sgrq_pkg::dp_status_t status,
  output sgrq_pkg::out_item_t out_data
);

  localparam int SEQ_W = sgrq_pkg::SEQ_W;
  localparam int PTR_W = sgrq_pkg::PTR_W;
  localparam int OCW   = sgrq_pkg::OUT_CNT_W;

  logic [SEQ_W-1:0] mem [sgrq_pkg::QUEUE_DEPTH];

  logic             mode_r;
  logic [SEQ_W-1:0] seq_r;
  logic [SEQ_W-1:0] last_seen_r;
  logic [SEQ_W-1:0] v_r;
  logic [PTR_W-1:0] rptr_r;
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] cnt_r;
  logic [PTR_W-1:0] pushed_r;
  logic             gap_r;
  logic             drop_r;
  logic             pvalid_r;
  logic [SEQ_W-1:0] rd_data_r;
  sgrq_pkg::out_item_t out_data_r;

  logic             borrow;
  logic [SEQ_W-1:0] diff;
  logic [PTR_W-1:0] level;
  logic [PTR_W-1:0] space;
  logic [PTR_W:0]   space_p1;
  logic             gap_c;
  logic             drop_c;
  logic [PTR_W-1:0] n_c;
  logic             pop_c;
  logic             rd_en;

  // one wide subtract gives both the compare and the distance
  assign {borrow, diff} = {1'b0, seq_r} - {1'b0, last_seen_r};
  assign level    = wptr_r - rptr_r;
  assign space    = PTR_W'(sgrq_pkg::QUEUE_DEPTH - 1) - level;
  assign space_p1 = {1'b0, space} + (PTR_W+1)'(1);
  assign gap_c    = !borrow && (|diff[SEQ_W-1:1]);
  assign drop_c   = gap_c && ((|diff[SEQ_W-1:PTR_W+1]) || (diff[PTR_W:0] > space_p1));

  always_comb begin
    if (!gap_c) begin
      n_c = '0;
    end else if (drop_c) begin
      n_c = space;
    end else begin
      n_c = PTR_W'(diff[PTR_W:0] - (PTR_W+1)'(1));
    end
  end

  assign pop_c = mode_r && (level != '0);
  assign rd_en = cmd.eval && pop_c;

  assign status.more     = !mode_r && (n_c != '0);
  assign status.cnt_last = (cnt_r == PTR_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seen_r <= '0;
      rptr_r      <= '0;
      wptr_r      <= '0;
    end else begin
      if (cmd.eval && !mode_r) begin
        last_seen_r <= seq_r;
      end
      if (rd_en) begin
        rptr_r <= rptr_r + PTR_W'(1);
      end
      if (cmd.push) begin
        wptr_r <= wptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_data.mode;
      seq_r  <= in_data.seq_value;
    end
    if (cmd.eval) begin
      if (!mode_r) begin
        gap_r    <= gap_c;
        drop_r   <= drop_c;
        pushed_r <= n_c;
        cnt_r    <= n_c;
        v_r      <= last_seen_r + SEQ_W'(1);
        pvalid_r <= 1'b0;
      end else begin
        gap_r    <= 1'b0;
        drop_r   <= 1'b0;
        pushed_r <= '0;
        cnt_r    <= '0;
        pvalid_r <= pop_c;
      end
    end
    if (cmd.push) begin
      v_r   <= v_r + SEQ_W'(1);
      cnt_r <= cnt_r - PTR_W'(1);
    end
    if (cmd.out_load) begin
      out_data_r.gap_found    <= gap_r;
      out_data_r.pushed_count <= OCW'(pushed_r);
      out_data_r.dropped      <= drop_r;
      out_data_r.popped_valid <= pvalid_r;
      out_data_r.popped_seq   <= pvalid_r ? rd_data_r : '0;
      out_data_r.queue_level  <= OCW'(level);
    end
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wptr_r] <= v_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rptr_r];
    end
  end

  assign out_data = out_data_r;

endmodule

[design/sgrq_ctrl.sv]
// ----------------------------------------------------------------------------
// sgrq_ctrl
// controller: sequences evaluate, push burst and result hand-off
// ----------------------------------------------------------------------------
module sgrq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sgrq_pkg::dp_status_t status,
  output sgrq_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_PUSH,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_OUT) && slot_free);
  assign accept    = in_valid && in_ready;

  assign cmd.load     = accept;
  assign cmd.eval     = (state_r == S_EVAL);
  assign cmd.push     = (state_r == S_PUSH);
  assign cmd.out_load = (state_r == S_OUT) && slot_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = status.more ? S_PUSH : S_OUT;
      end
      S_PUSH: begin
        if (status.cnt_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = accept ? S_EVAL : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
